// ===== src/bkm_pkg.sv =====
package bkm_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 256;
  localparam int unsigned MAX_CENTERS_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF    = 8;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned RES_W     = 48;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RES_W-1:0] ERR_MAX = 48'h7FFF_FFFF_FFFF;

  localparam logic [8:0] NUM_POINTS_RST  = 9'd256;
  localparam logic [4:0] NUM_CENTERS_RST = 5'd4;
  localparam logic [3:0] NUM_DIMS_RST    = 4'd2;
  localparam logic [7:0] MAX_ITER_RST    = 8'd10;

  typedef enum logic [2:0] {
    CMD_LOAD_POINT,
    CMD_LOAD_CENTER,
    CMD_RUN,
    CMD_READ_LABEL,
    CMD_READ_CENTER,
    CMD_READ_COUNT,
    CMD_READ_ERROR,
    CMD_READ_PASSES
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_POINTS,
    REG_NUM_CENTERS,
    REG_NUM_DIMS,
    REG_MAX_ITER
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RSP,
    ST_PASS_INIT,
    ST_CLAIM_INIT,
    ST_SCAN,
    ST_DIST,
    ST_DRAIN,
    ST_CCMP,
    ST_LRD,
    ST_LCMP,
    ST_PASS_END,
    ST_MSCAN_START,
    ST_MSCAN,
    ST_MDRAIN,
    ST_MDIV,
    ST_MDIVW,
    ST_MWRITE,
    ST_FIN_INIT,
    ST_FIN_PT,
    ST_FCMP,
    ST_FIN_WR
  } st_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         item_index;
    logic [2:0]         dim_index;
    logic signed [15:0] coord_value;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic               status;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } sq_ctl_t;

endpackage

// ===== src/bkm_ram.sv =====
module bkm_ram import bkm_pkg::*; #(
  parameter int unsigned W = 16,
  parameter int unsigned D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bkm_sqacc.sv =====
module bkm_sqacc import bkm_pkg::*; #(
  parameter int unsigned DISTW = 35
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sq_ctl_t            ctl_i,
  input  logic signed [15:0] pt_i,
  input  logic signed [15:0] cen_i,
  output logic [DISTW-1:0]   acc_o
);

  logic signed [16:0] diff;
  logic        [16:0] mag;
  logic        [31:0] prod_d, prod_q;
  logic               pv_q;
  logic [DISTW-1:0]   acc_d, acc_q;

  // squared difference of one coordinate pair, then running sum
  always_comb begin
    diff   = 17'(pt_i) - 17'(cen_i);
    mag    = diff[16] ? 17'(-diff) : 17'(diff);
    prod_d = mag[15:0] * mag[15:0];
    acc_d  = (ctl_i.clear ? '0 : acc_q) + (pv_q ? DISTW'(prod_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== src/bkm_div.sv =====
module bkm_div import bkm_pkg::*; #(
  parameter int unsigned MW = 24,
  parameter int unsigned CW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic [MW-1:0] quot_o,
  output logic          done_o
);

  localparam int unsigned SCW = $clog2(MW + 1);

  logic [MW-1:0]  q_d, q_q;
  logic [CW-1:0]  r_d, r_q, d_q;
  logic [SCW-1:0] cnt_d, cnt_q;
  logic           busy_d, busy_q, done_d, done_q;
  logic [CW:0]    shifted, trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted = {r_q, q_q[MW-1]};
    trial   = shifted - {1'b0, d_q};
    q_d     = q_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      cnt_d  = SCW'(MW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[CW]) begin
        r_d = trial[CW-1:0];
        q_d = {q_q[MW-2:0], 1'b1};
      end else begin
        r_d = shifted[CW-1:0];
        q_d = {q_q[MW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == SCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

// ===== src/balanced_kmeans_clustering.sv =====
// balanced k-means engine with one shared squared-difference accumulator
// input channel: valid/ready, one command word per handshake (loads, run, reads)
// output channel: valid/ready, exactly one result word per command word
// configuration: plain write port, cfg_we_i with cfg_idx_i and cfg_data_i,
// only to be used while the engine is idle
// loads and count, error and pass reads: result valid in the cycle after acceptance,
// one word per cycle sustained while the receiver keeps up
// label and centre reads: the result passes the registered memory read and a response state
// run: a claim scans every point, skipping claimed ones and computing the distance of
// each free one, and a pass runs claims until every point is taken; the mean update
// then scans all points for each centre coordinate and divides the member sum when
// the coordinate has members; the final assignment finds each point's nearest centre
// reset: registers to their defaults, labels unassigned, counts and errors zero;
// point and centre memories hold nothing until loaded
// a stalled receiver holds the result word; a new command is taken only when the
// output register is empty or being emptied
module balanced_kmeans_clustering import bkm_pkg::*; #(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int unsigned MAX_DIMS    = MAX_DIMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned PIW   = $clog2(MAX_POINTS);
  localparam int unsigned NW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned KIW   = $clog2(MAX_CENTERS);
  localparam int unsigned KW    = $clog2(MAX_CENTERS + 1);
  localparam int unsigned DCW   = $clog2(MAX_DIMS + 1);
  localparam int unsigned PAW   = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int unsigned CAW   = $clog2(MAX_CENTERS * MAX_DIMS);
  localparam int unsigned DISTW = 32 + $clog2(MAX_DIMS);
  localparam int unsigned SUMW  = COORD_W + $clog2(MAX_POINTS) + 1;
  localparam int unsigned MW    = SUMW - 1;

  // configuration registers
  logic [8:0] npts_q;
  logic [4:0] ncen_q;
  logic [3:0] ndim_q;
  logic [7:0] mit_q;

  // clamped working values
  logic [NW-1:0]  n;
  logic [KW-1:0]  k;
  logic [DCW-1:0] p;
  logic [7:0]     mi;

  always_comb begin
    n  = (npts_q == '0) ? NW'(1) :
         ((npts_q > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(npts_q));
    k  = (ncen_q == '0) ? KW'(1) :
         ((ncen_q > MAX_CENTERS) ? KW'(MAX_CENTERS) : KW'(ncen_q));
    p  = (ndim_q == '0) ? DCW'(1) :
         ((ndim_q > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(ndim_q));
    mi = (mit_q == '0) ? 8'd1 : mit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npts_q <= NUM_POINTS_RST;
      ncen_q <= NUM_CENTERS_RST;
      ndim_q <= NUM_DIMS_RST;
      mit_q  <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_NUM_POINTS:  npts_q <= cfg_data_i[8:0];
        REG_NUM_CENTERS: ncen_q <= cfg_data_i[4:0];
        REG_NUM_DIMS:    ndim_q <= cfg_data_i[3:0];
        REG_MAX_ITER:    mit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  st_e               state_d, state_q;
  logic              final_d, final_q;
  logic [NW-1:0]     pi_d, pi_q;
  logic [KIW-1:0]    cen_d, cen_q;
  logic [DCW-1:0]    c_d, c_q;
  logic              drn_d, drn_q;
  logic              found_d, found_q;
  logic [NW-1:0]     count_d, count_q;
  logic              upd_d, upd_q;
  logic [7:0]        iter_d, iter_q;
  logic [8:0]        passes_d, passes_q;
  logic              rd_vld_d, rd_vld_q;
  logic              mv_d, mv_q;
  logic [MAX_POINTS-1:0] claimed_d, claimed_q;
  logic [MAX_POINTS-1:0] lab_vld_d, lab_vld_q;
  logic [NW-1:0]     cnt_d [MAX_CENTERS];
  logic [NW-1:0]     cnt_q [MAX_CENTERS];
  logic [RES_W-1:0]  err_d [MAX_CENTERS];
  logic [RES_W-1:0]  err_q [MAX_CENTERS];

  // working data
  logic [DISTW-1:0]       best_d_d, best_d_q;
  logic [PIW-1:0]         best_i_d, best_i_q;
  logic [KIW-1:0]         best_c_d, best_c_q;
  logic signed [SUMW-1:0] sum_d, sum_q;
  logic [NW-1:0]          mcnt_d, mcnt_q;
  logic                   rsp_lab_d, rsp_lab_q, rsp_vld_d, rsp_vld_q;

  // output register
  logic      out_valid_q, out_set;
  out_word_t out_d, out_q;

  // memory ports
  logic                      p_we, c_we, l_we;
  logic [PAW-1:0]            p_addr;
  logic [CAW-1:0]            c_addr;
  logic [PIW-1:0]            l_addr;
  logic signed [COORD_W-1:0] p_wd, c_wd, pt_rd, cen_rd;
  logic [KIW-1:0]            l_wd, lab_rd;

  sq_ctl_t          sq_ctl;
  logic [DISTW-1:0] acc;
  logic             div_start, div_done;
  logic [MW-1:0]    div_dvd, quot;
  logic [15:0]      q16;
  logic signed [15:0] mean;

  logic              accept;
  logic              item_pt_ok, item_cen_ok, dim_ok;
  logic [PIW-1:0]    item_pi;
  logic [KIW-1:0]    item_ci;
  logic [RES_W:0]    err_sum;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign item_pt_ok  = in_word_i.item_index < n;
  assign item_cen_ok = in_word_i.item_index < k;
  assign dim_ok      = in_word_i.dim_index < p;
  assign item_pi     = PIW'(in_word_i.item_index);
  assign item_ci     = KIW'(in_word_i.item_index);

  // mean of a centre coordinate: magnitude divided, sign put back, truncation toward zero
  assign div_dvd = sum_q[SUMW-1] ? MW'(-sum_q) : MW'(sum_q);
  assign q16     = quot[15:0];
  assign mean    = (mcnt_q == '0) ? '0 :
                   (sum_q[SUMW-1] ? signed'(-q16) : signed'(q16));

  always_comb begin
    state_d   = state_q;
    final_d   = final_q;
    pi_d      = pi_q;
    cen_d     = cen_q;
    c_d       = c_q;
    drn_d     = drn_q;
    found_d   = found_q;
    count_d   = count_q;
    upd_d     = upd_q;
    iter_d    = iter_q;
    passes_d  = passes_q;
    claimed_d = claimed_q;
    lab_vld_d = lab_vld_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    best_d_d  = best_d_q;
    best_i_d  = best_i_q;
    best_c_d  = best_c_q;
    sum_d     = sum_q;
    mcnt_d    = mcnt_q;
    rsp_lab_d = rsp_lab_q;
    rsp_vld_d = rsp_vld_q;
    rd_vld_d  = 1'b0;
    mv_d      = 1'b0;
    div_start = 1'b0;
    out_set   = 1'b0;
    out_d     = out_q;
    err_sum   = '0;

    // default addressing follows the current point, centre and coordinate
    p_we   = 1'b0;
    p_addr = PAW'(pi_q[PIW-1:0] * MAX_DIMS + c_q);
    p_wd   = in_word_i.coord_value;
    c_we   = 1'b0;
    c_addr = CAW'(cen_q * MAX_DIMS + c_q);
    c_wd   = in_word_i.coord_value;
    l_we   = 1'b0;
    l_addr = pi_q[PIW-1:0];
    l_wd   = cen_q;

    sq_ctl.clear = 1'b0;
    sq_ctl.vld   = rd_vld_q;

    // member sums follow the label and point reads, in the cycle after each read is issued
    if (mv_q && (lab_rd == cen_q)) begin
      sum_d  = sum_q + SUMW'(pt_rd);
      mcnt_d = mcnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_set            = 1'b1;
          out_d.result_value = '0;
          out_d.status       = 1'b0;
          unique case (cmd_e'(in_word_i.command))
            CMD_LOAD_POINT: begin
              if (item_pt_ok && dim_ok) begin
                p_we   = 1'b1;
                p_addr = PAW'(in_word_i.item_index * MAX_DIMS + in_word_i.dim_index);
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_LOAD_CENTER: begin
              if (item_cen_ok && dim_ok) begin
                c_we   = 1'b1;
                c_addr = CAW'(in_word_i.item_index * MAX_DIMS + in_word_i.dim_index);
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_RUN: begin
              out_set   = 1'b0;
              lab_vld_d = '0;
              iter_d    = '0;
              state_d   = ST_PASS_INIT;
            end
            CMD_READ_LABEL: begin
              if (item_pt_ok) begin
                out_set   = 1'b0;
                l_addr    = item_pi;
                rsp_lab_d = 1'b1;
                rsp_vld_d = lab_vld_q[item_pi];
                state_d   = ST_RSP;
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_READ_CENTER: begin
              if (item_cen_ok && dim_ok) begin
                out_set   = 1'b0;
                c_addr    = CAW'(in_word_i.item_index * MAX_DIMS + in_word_i.dim_index);
                rsp_lab_d = 1'b0;
                state_d   = ST_RSP;
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_READ_COUNT: begin
              if (item_cen_ok) begin
                out_d.result_value = RES_W'(cnt_q[item_ci]);
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_READ_ERROR: begin
              if (item_cen_ok) begin
                out_d.result_value = err_q[item_ci];
              end else begin
                out_d.status = 1'b1;
              end
            end
            CMD_READ_PASSES: begin
              out_d.result_value = RES_W'(passes_q);
            end
            default: ;
          endcase
        end
      end

      ST_RSP: begin
        out_set      = 1'b1;
        out_d.status = 1'b0;
        if (rsp_lab_q) begin
          out_d.result_value = rsp_vld_q ? RES_W'(lab_rd) : '1;
        end else begin
          out_d.result_value = RES_W'(cen_rd);
        end
        state_d = ST_IDLE;
      end

      // balanced pass: centres claim points in turn
      ST_PASS_INIT: begin
        claimed_d = '0;
        upd_d     = 1'b0;
        count_d   = '0;
        cen_d     = '0;
        state_d   = ST_CLAIM_INIT;
      end

      ST_CLAIM_INIT: begin
        found_d = 1'b0;
        pi_d    = '0;
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (pi_q == n) begin
          state_d = ST_LRD;
        end else if (claimed_q[pi_q[PIW-1:0]]) begin
          pi_d = pi_q + 1'b1;
        end else begin
          c_d     = '0;
          state_d = ST_DIST;
        end
      end

      // stream one coordinate pair per cycle into the accumulator
      ST_DIST: begin
        rd_vld_d     = 1'b1;
        sq_ctl.clear = (c_q == '0);
        c_d          = c_q + 1'b1;
        if ((c_q + 1'b1) == p) begin
          drn_d   = 1'b0;
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        drn_d = 1'b1;
        if (drn_q) begin
          state_d = final_q ? ST_FCMP : ST_CCMP;
        end
      end

      ST_CCMP: begin
        if (!found_q || (acc < best_d_q)) begin
          found_d  = 1'b1;
          best_d_d = acc;
          best_i_d = pi_q[PIW-1:0];
        end
        pi_d    = pi_q + 1'b1;
        state_d = ST_SCAN;
      end

      ST_LRD: begin
        l_addr  = best_i_q;
        state_d = ST_LCMP;
      end

      ST_LCMP: begin
        if (!lab_vld_q[best_i_q] || (lab_rd != cen_q)) begin
          l_we                = 1'b1;
          l_addr              = best_i_q;
          l_wd                = cen_q;
          lab_vld_d[best_i_q] = 1'b1;
          upd_d               = 1'b1;
        end
        claimed_d[best_i_q] = 1'b1;
        count_d             = count_q + 1'b1;
        cen_d               = ((KW'(cen_q) + 1'b1) == k) ? '0 : cen_q + 1'b1;
        state_d             = ((count_q + 1'b1) == n) ? ST_PASS_END : ST_CLAIM_INIT;
      end

      ST_PASS_END: begin
        if (!upd_q) begin
          passes_d = 9'(iter_q) + 9'd1;
          state_d  = ST_FIN_INIT;
        end else begin
          cen_d   = '0;
          c_d     = '0;
          state_d = ST_MSCAN_START;
        end
      end

      // mean update, one centre coordinate at a time
      ST_MSCAN_START: begin
        sum_d   = '0;
        mcnt_d  = '0;
        pi_d    = '0;
        state_d = ST_MSCAN;
      end

      ST_MSCAN: begin
        if (pi_q == n) begin
          state_d = ST_MDRAIN;
        end else begin
          mv_d = 1'b1;
          pi_d = pi_q + 1'b1;
        end
      end

      ST_MDRAIN: begin
        state_d = ST_MDIV;
      end

      ST_MDIV: begin
        if (mcnt_q == '0) begin
          state_d = ST_MWRITE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_MDIVW;
        end
      end

      ST_MDIVW: begin
        if (div_done) begin
          state_d = ST_MWRITE;
        end
      end

      ST_MWRITE: begin
        c_we = 1'b1;
        c_wd = mean;
        if ((c_q + 1'b1) == p) begin
          c_d = '0;
          if ((KW'(cen_q) + 1'b1) == k) begin
            if ((iter_q + 1'b1) == mi) begin
              passes_d = 9'(mi) + 9'd1;
              state_d  = ST_FIN_INIT;
            end else begin
              iter_d  = iter_q + 1'b1;
              state_d = ST_PASS_INIT;
            end
          end else begin
            cen_d   = cen_q + 1'b1;
            state_d = ST_MSCAN_START;
          end
        end else begin
          c_d     = c_q + 1'b1;
          state_d = ST_MSCAN_START;
        end
      end

      // final nearest-centre assignment with counts and error sums
      ST_FIN_INIT: begin
        for (int j = 0; j < MAX_CENTERS; j++) begin
          cnt_d[j] = '0;
          err_d[j] = '0;
        end
        pi_d    = '0;
        final_d = 1'b1;
        state_d = ST_FIN_PT;
      end

      ST_FIN_PT: begin
        if (pi_q == n) begin
          out_set            = 1'b1;
          out_d.result_value = RES_W'(passes_q);
          out_d.status       = 1'b0;
          final_d            = 1'b0;
          state_d            = ST_IDLE;
        end else begin
          cen_d   = '0;
          c_d     = '0;
          state_d = ST_DIST;
        end
      end

      ST_FCMP: begin
        if ((cen_q == '0) || (acc < best_d_q)) begin
          best_d_d = acc;
          best_c_d = cen_q;
        end
        if ((KW'(cen_q) + 1'b1) == k) begin
          state_d = ST_FIN_WR;
        end else begin
          cen_d   = cen_q + 1'b1;
          c_d     = '0;
          state_d = ST_DIST;
        end
      end

      ST_FIN_WR: begin
        l_we                      = 1'b1;
        l_wd                      = best_c_q;
        lab_vld_d[pi_q[PIW-1:0]]  = 1'b1;
        cnt_d[best_c_q]           = cnt_q[best_c_q] + 1'b1;
        err_sum                   = {1'b0, err_q[best_c_q]} + (RES_W+1)'(best_d_q);
        err_d[best_c_q]           = (err_sum > ERR_MAX) ? ERR_MAX : err_sum[RES_W-1:0];
        pi_d                      = pi_q + 1'b1;
        state_d                   = ST_FIN_PT;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      final_q     <= 1'b0;
      pi_q        <= '0;
      cen_q       <= '0;
      c_q         <= '0;
      drn_q       <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      upd_q       <= 1'b0;
      iter_q      <= '0;
      passes_q    <= '0;
      rd_vld_q    <= 1'b0;
      mv_q        <= 1'b0;
      claimed_q   <= '0;
      lab_vld_q   <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_CENTERS; j++) begin
        cnt_q[j] <= '0;
        err_q[j] <= '0;
      end
    end else begin
      state_q   <= state_d;
      final_q   <= final_d;
      pi_q      <= pi_d;
      cen_q     <= cen_d;
      c_q       <= c_d;
      drn_q     <= drn_d;
      found_q   <= found_d;
      count_q   <= count_d;
      upd_q     <= upd_d;
      iter_q    <= iter_d;
      passes_q  <= passes_d;
      rd_vld_q  <= rd_vld_d;
      mv_q      <= mv_d;
      claimed_q <= claimed_d;
      lab_vld_q <= lab_vld_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_d_q  <= best_d_d;
    best_i_q  <= best_i_d;
    best_c_q  <= best_c_d;
    sum_q     <= sum_d;
    mcnt_q    <= mcnt_d;
    rsp_lab_q <= rsp_lab_d;
    rsp_vld_q <= rsp_vld_d;
    if (out_set) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  bkm_ram #(.W(COORD_W), .D(MAX_POINTS * MAX_DIMS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .addr_i  (p_addr),
    .wdata_i (p_wd),
    .rdata_o (pt_rd)
  );

  bkm_ram #(.W(COORD_W), .D(MAX_CENTERS * MAX_DIMS)) u_center_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .addr_i  (c_addr),
    .wdata_i (c_wd),
    .rdata_o (cen_rd)
  );

  bkm_ram #(.W(KIW), .D(MAX_POINTS)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .addr_i  (l_addr),
    .wdata_i (l_wd),
    .rdata_o (lab_rd)
  );

  bkm_sqacc #(.DISTW(DISTW)) u_sqacc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .pt_i   (pt_rd),
    .cen_i  (cen_rd),
    .acc_o  (acc)
  );

  bkm_div #(.MW(MW), .CW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (mcnt_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // the point a centre claims was still free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LCMP |-> !claimed_q[best_i_q] && found_q)
    else $error("claimed point chosen twice");

  // accumulator data only follows a coordinate read of a distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_DIST)
    else $error("stray distance data");

  // divider completes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_MDIVW)
    else $error("unexpected divider completion");

  // a run leaves the first point with a label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN_PT && pi_q == n |-> lab_vld_q[0])
    else $error("run ended without labels");

endmodule

// ===== test/balanced_kmeans_clustering_tb.sv =====
module balanced_kmeans_clustering_tb;
  import bkm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP = MAX_POINTS_DEF;
  localparam int NC = MAX_CENTERS_DEF;
  localparam int ND = MAX_DIMS_DEF;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int LONG_HOLD = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  balanced_kmeans_clustering dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words waiting to be offered, and the results they should produce
  in_word_t cmd_pending[$];
  out_word_t result_due[$];

  int errors = 0;
  int words_sent = 0;
  int runs_done = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_req = 0;

  // shadow of the configuration registers, raw as written
  int unsigned sh_points = NUM_POINTS_RST;
  int unsigned sh_centers = NUM_CENTERS_RST;
  int unsigned sh_dims = NUM_DIMS_RST;
  int unsigned sh_iter = MAX_ITER_RST;

  // shadow of the engine state
  logic signed [15:0] pt_mem[NP*ND];
  bit pt_known[NP*ND];
  logic signed [15:0] ctr_mem[NC*ND];
  bit ctr_known[NC*ND];
  int unsigned lbl[NP];
  bit lbl_set[NP];
  bit taken[NP];
  longint csum[NC*ND];
  int unsigned members[NC];
  longint unsigned sq_err[NC];
  int unsigned pass_cnt = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned sq_dist(int i, int j, int p);
    longint unsigned s;
    longint d;
    s = 0;
    for (int c = 0; c < p; c++) begin
      d = longint'(pt_mem[i*ND+c]) - longint'(ctr_mem[j*ND+c]);
      s += longint'(d * d);
    end
    return s;
  endfunction

  // works out the result word of one command and advances the shadow state
  function automatic out_word_t cluster_result(in_word_t w);
    out_word_t r;
    int n, k, p, mi, iter, count, bi, t;
    int item, dim;
    bit upd, found;
    longint unsigned bd, d;
    longint res;
    n = clamp(sh_points, NP);
    k = clamp(sh_centers, NC);
    p = clamp(sh_dims, ND);
    mi = clamp(sh_iter, 255);
    item = w.item_index;
    dim = w.dim_index;
    res = 0;
    r.status = 1'b0;
    case (cmd_e'(w.command))
      CMD_LOAD_POINT: begin
        if (item < n && dim < p) begin
          pt_mem[item*ND+dim] = w.coord_value;
          pt_known[item*ND+dim] = 1'b1;
        end else r.status = 1'b1;
      end
      CMD_LOAD_CENTER: begin
        if (item < k && dim < p) begin
          ctr_mem[item*ND+dim] = w.coord_value;
          ctr_known[item*ND+dim] = 1'b1;
        end else r.status = 1'b1;
      end
      CMD_RUN: begin
        for (int i = 0; i < NP; i++) lbl_set[i] = 1'b0;
        for (iter = 0; iter < mi; iter++) begin
          upd = 1'b0;
          count = 0;
          for (int i = 0; i < NP; i++) taken[i] = 1'b0;
          // centres take turns claiming their nearest free point
          while (count < n) begin
            for (int j = 0; j < k && count < n; j++) begin
              found = 1'b0;
              bi = 0;
              bd = 0;
              for (int i = 0; i < n; i++) begin
                if (!taken[i]) begin
                  d = sq_dist(i, j, p);
                  if (!found || d < bd) begin
                    found = 1'b1;
                    bd = d;
                    bi = i;
                  end
                end
              end
              if (!lbl_set[bi] || lbl[bi] != j) begin
                lbl[bi] = j;
                lbl_set[bi] = 1'b1;
                upd = 1'b1;
              end
              taken[bi] = 1'b1;
              count++;
            end
          end
          if (!upd) break;
          for (int x = 0; x < NC*ND; x++) csum[x] = 0;
          for (int x = 0; x < NC; x++) members[x] = 0;
          for (int i = 0; i < n; i++) begin
            t = lbl[i] % NC;
            members[t]++;
            for (int c = 0; c < p; c++) csum[t*ND+c] += pt_mem[i*ND+c];
          end
          // means truncate toward zero, an empty centre goes to zero
          for (int j = 0; j < k; j++)
            for (int c = 0; c < p; c++) begin
              ctr_mem[j*ND+c] = (members[j] == 0) ? 16'sd0
                              : 16'(csum[j*ND+c] / longint'(members[j]));
              ctr_known[j*ND+c] = 1'b1;
            end
        end
        pass_cnt = iter + 1;
        for (int x = 0; x < NC; x++) begin
          members[x] = 0;
          sq_err[x] = 0;
        end
        for (int i = 0; i < n; i++) begin
          bi = 0;
          bd = sq_dist(i, 0, p);
          for (int j = 1; j < k; j++) begin
            d = sq_dist(i, j, p);
            if (d < bd) begin
              bd = d;
              bi = j;
            end
          end
          lbl[i] = bi;
          lbl_set[i] = 1'b1;
          members[bi]++;
          sq_err[bi] += bd;
          if (sq_err[bi] > ERR_MAX) sq_err[bi] = ERR_MAX;
        end
        res = pass_cnt;
      end
      CMD_READ_LABEL: begin
        if (item < n) res = lbl_set[item] ? longint'(lbl[item]) : -1;
        else r.status = 1'b1;
      end
      CMD_READ_CENTER: begin
        if (item < k && dim < p) res = ctr_mem[item*ND+dim];
        else r.status = 1'b1;
      end
      CMD_READ_COUNT: begin
        if (item < k) res = members[item];
        else r.status = 1'b1;
      end
      CMD_READ_ERROR: begin
        if (item < k) res = longint'(sq_err[item]);
        else r.status = 1'b1;
      end
      default: res = pass_cnt;
    endcase
    r.result_value = res[47:0];
    return r;
  endfunction

  function automatic in_word_t mk(cmd_e c, int item, int dim, int val);
    in_word_t w;
    w.command = c;
    w.item_index = item[7:0];
    w.dim_index = dim[2:0];
    w.coord_value = val[15:0];
    return w;
  endfunction

  task automatic send(in_word_t w);
    result_due.push_back(cluster_result(w));
    cmd_pending.push_back(w);
    words_sent++;
    if (w.command == CMD_RUN) runs_done++;
  endtask

  // wait until every result is back, then let the engine settle
  task automatic drain();
    while (cmd_pending.size() != 0 || result_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // all four registers in back-to-back cycles
  task automatic write_cfg(int unsigned n, int unsigned k, int unsigned p, int unsigned mi);
    int unsigned v[4];
    v[0] = n & 9'h1ff;
    v[1] = k & 5'h1f;
    v[2] = p & 4'hf;
    v[3] = mi & 8'hff;
    drain();
    for (int r = 0; r < 4; r++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_e'(r);
      cfg_data_i <= v[r][CFG_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_points = v[0];
    sh_centers = v[1];
    sh_dims = v[2];
    sh_iter = v[3];
  endtask

  function automatic int coord_pick(bit narrow);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (narrow) return $urandom_range(0, 6) - 3;
    return $urandom;
  endfunction

  // a word of junk: any command but run, random fields
  task automatic send_noise();
    in_word_t w;
    logic [31:0] raw;
    int k, p;
    k = clamp(sh_centers, NC);
    p = clamp(sh_dims, ND);
    raw = $urandom;
    w = raw[$bits(in_word_t)-1:0];
    if (w.command == CMD_RUN) w.command = CMD_READ_PASSES;
    // never read a centre coordinate that holds nothing yet
    if (w.command == CMD_READ_CENTER && w.item_index < k && w.dim_index < p &&
        !ctr_known[w.item_index*ND+w.dim_index])
      w.command = CMD_READ_PASSES;
    send(w);
  endtask

  // one full job: configure, load everything in shuffled order, run, read back
  task automatic cluster_job(int unsigned rn, int unsigned rk, int unsigned rp,
                             int unsigned rmi, bit narrow, bit with_hold);
    int n, k, p, tmp, sw, slots;
    int order[];
    write_cfg(rn, rk, rp, rmi);
    n = clamp(sh_points, NP);
    k = clamp(sh_centers, NC);
    p = clamp(sh_dims, ND);
    slots = (n + k) * p;
    order = new[slots];
    for (int x = 0; x < slots; x++) order[x] = x;
    for (int x = slots - 1; x > 0; x--) begin
      sw = $urandom_range(0, x);
      tmp = order[x];
      order[x] = order[sw];
      order[sw] = tmp;
    end
    for (int x = 0; x < slots; x++) begin
      if (!quiet && $urandom_range(0, 7) == 0) send_noise();
      if (order[x] < n * p)
        send(mk(CMD_LOAD_POINT, order[x] / p, order[x] % p, coord_pick(narrow)));
      else
        send(mk(CMD_LOAD_CENTER, (order[x] - n*p) / p, (order[x] - n*p) % p,
                coord_pick(narrow)));
    end
    send(mk(CMD_RUN, $urandom, $urandom, $urandom));
    if (with_hold) hold_req++;
    for (int i = 0; i < n; i++) send(mk(CMD_READ_LABEL, i, $urandom, $urandom));
    for (int j = 0; j < k; j++) begin
      send(mk(CMD_READ_COUNT, j, $urandom, $urandom));
      send(mk(CMD_READ_ERROR, j, $urandom, $urandom));
      for (int c = 0; c < p; c++) send(mk(CMD_READ_CENTER, j, c, $urandom));
    end
    send(mk(CMD_READ_PASSES, $urandom, $urandom, $urandom));
    // out of range reads and an out of range centre load
    if (n < NP) send(mk(CMD_READ_LABEL, $urandom_range(n, 255), 0, 0));
    send(mk(CMD_READ_COUNT, $urandom_range(k, 255), 0, 0));
    send(mk(CMD_READ_CENTER, $urandom_range(0, k - 1), $urandom_range(p, 7), 0));
    send(mk(CMD_LOAD_CENTER, $urandom_range(k, 255), 0, $urandom));
  endtask

  // sender side: offer the next word once the previous one has gone
  logic in_taken = 1'b0;
  int in_gap = 0;

  always @(posedge clk_i) in_taken <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        in_word_i <= cmd_pending.pop_front();
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver side: random short stalls, and a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  int out_gap = 0;

  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 8);
    end
  end

  // checker: each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    out_word_t exp_w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, result_due.size());
      $display("status: fail");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_due.size() == 0) begin
        $display("%0t unexpected word value %0d status %0d", $time,
                 out_word_o.result_value, out_word_o.status);
        errors <= errors + 1;
      end else begin
        exp_w = result_due.pop_front();
        if (exp_w.result_value !== out_word_o.result_value ||
            exp_w.status !== out_word_o.status) begin
          $display("%0t mismatch: expected value %0d status %0d, got value %0d status %0d",
                   $time, exp_w.result_value, exp_w.status,
                   out_word_o.result_value, out_word_o.status);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // straight after reset: unassigned labels, zero counts and passes, bad indexes
    send(mk(CMD_READ_LABEL, 0, 0, 0));
    send(mk(CMD_READ_LABEL, 255, 7, 0));
    send(mk(CMD_READ_PASSES, 0, 0, 0));
    send(mk(CMD_READ_COUNT, 3, 0, 0));
    send(mk(CMD_READ_ERROR, 0, 0, 0));
    send(mk(CMD_READ_COUNT, 4, 0, 0));
    send(mk(CMD_LOAD_POINT, 0, 2, 16'h1234));
    send(mk(CMD_READ_CENTER, 4, 0, 0));

    // tiny job: duplicate points for ties, more centres than points leaves one empty
    write_cfg(3, 4, 2, 10);
    send(mk(CMD_LOAD_POINT, 0, 0, 32767));
    send(mk(CMD_LOAD_POINT, 0, 1, -32768));
    send(mk(CMD_LOAD_POINT, 1, 0, 5));
    send(mk(CMD_LOAD_POINT, 1, 1, 5));
    send(mk(CMD_LOAD_POINT, 2, 0, 5));
    send(mk(CMD_LOAD_POINT, 2, 1, 5));
    for (int j = 0; j < 4; j++) begin
      send(mk(CMD_LOAD_CENTER, j, 0, -32768));
      send(mk(CMD_LOAD_CENTER, j, 1, 32767));
    end
    send(mk(CMD_RUN, 0, 0, 0));
    for (int i = 0; i < 3; i++) send(mk(CMD_READ_LABEL, i, 0, 0));
    send(mk(CMD_READ_COUNT, 3, 0, 0));
    send(mk(CMD_READ_CENTER, 3, 1, 0));
    send(mk(CMD_READ_ERROR, 0, 0, 0));
    send(mk(CMD_READ_PASSES, 0, 0, 0));

    // register extremes, zero and oversize values clamp
    cluster_job(0, 31, 15, 0, 1'b0, 1'b0);
    cluster_job(5, 31, 3, 255, 1'b1, 1'b0);
    cluster_job(2, 1, 1, 255, 1'b1, 1'b0);
    // full point store with one pass; the receiver holds off while the loads stream in
    cluster_job(511, 16, 1, 1, 1'b0, 1'b1);

    while (words_sent < 1450) begin
      if ($urandom_range(0, 5) == 0)
        cluster_job($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                    $urandom_range(1, 20), $urandom_range(0, 1), 1'b0);
      else
        cluster_job($urandom_range(1, 10), $urandom_range(1, 5), $urandom_range(1, 4),
                    $urandom_range(1, 12), $urandom_range(0, 1), 1'b0);
    end

    // last stretch at full rate on both sides
    drain();
    quiet = 1'b1;
    cluster_job($urandom_range(4, 10), $urandom_range(2, 4), 2, 10, 1'b1, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d command words over %0d clustering runs", words_sent, runs_done);
    $display("register extremes, empty centres, ties, bad indexes and long output stalls");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
